// ===== hw/rtl/swk_pkg.sv =====
// ============================================================================
// swk_pkg: shared types and constants for the swerve wheel kinematics unit
// Pipeline depths, cell payload structs, register codes and the CORDIC
// arctangent table.
// ============================================================================
package swk_pkg;

    // CORDIC depth, valid from 8 to 24
    localparam int CORDIC_STAGES = 16;
    localparam int STG_W         = 5;

    // Square root: two radicand bits per cell over a 34-bit radicand
    localparam int SQRT_CELLS = 17;
    // Normalizing divide: one quotient bit per cell
    localparam int DIV_CELLS  = 16;

    // Stage numbering, counted from the accepting edge (stage 1)
    localparam int SQRT_IN_STAGE = 4;
    localparam int DIV_IN_STAGE  = SQRT_IN_STAGE + SQRT_CELLS + 1;
    localparam int LAT           = DIV_IN_STAGE + DIV_CELLS + 1;
    // CORDIC input register sits at stage 3; pad angles up to stage LAT-1
    localparam int ANG_DLY       = LAT - 1 - 3 - CORDIC_STAGES;

    localparam logic [15:0] RATIO_RST = 16'd46341;
    localparam logic [16:0] ONE_Q15   = 17'd32768;
    localparam logic [15:0] HALF_TURN = 16'h8000;

    // register select, taken from paddr[2]
    localparam logic REG_LENGTH = 1'b0;
    localparam logic REG_WIDTH  = 1'b1;

    typedef logic signed [33:0] cvec_t;

    typedef struct packed {
        cvec_t       x;
        cvec_t       y;
        logic [31:0] z;
        logic        zero;
    } cordic_t;

    typedef struct packed {
        logic [33:0] n;
        logic [17:0] rem;
        logic [16:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [16:0] m;
        logic [16:0] s;
        logic        big;
        logic [16:0] rem;
        logic [15:0] quo;
        logic [15:0] dsh;
    } div_t;

    // atan(2^-i) with 2^32 units per turn
    function automatic logic [31:0] atan_entry(input logic [STG_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/swk_if.sv =====
// ============================================================================
// swk_if: command and wheel result channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ============================================================================
interface swk_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive_x;
    logic signed [15:0] drive_y;
    logic signed [15:0] rotate;

    modport source (output valid, output drive_x, output drive_y, output rotate,
                    input ready);
    modport sink   (input valid, input drive_x, input drive_y, input rotate,
                    output ready);
endinterface

interface swk_wheel_if;
    logic        valid;
    logic        ready;
    logic [15:0] wheel1_speed;
    logic [15:0] wheel2_speed;
    logic [15:0] wheel3_speed;
    logic [15:0] wheel4_speed;
    logic [15:0] wheel1_angle;
    logic [15:0] wheel2_angle;
    logic [15:0] wheel3_angle;
    logic [15:0] wheel4_angle;

    modport source (output valid, output wheel1_speed, output wheel2_speed,
                    output wheel3_speed, output wheel4_speed, output wheel1_angle,
                    output wheel2_angle, output wheel3_angle, output wheel4_angle,
                    input ready);
    modport sink   (input valid, input wheel1_speed, input wheel2_speed,
                    input wheel3_speed, input wheel4_speed, input wheel1_angle,
                    input wheel2_angle, input wheel3_angle, input wheel4_angle,
                    output ready);
endinterface

// ===== hw/rtl/swk_sqrt_cell.sv =====
// ============================================================================
// swk_sqrt_cell: one digit of the integer square root chain
// Bring down two radicand bits, try the next root bit, keep the remainder.
// ============================================================================
module swk_sqrt_cell (
    input  logic          clk,
    input  logic          en,
    input  swk_pkg::sqrt_t cin,
    output swk_pkg::sqrt_t cout
);
    import swk_pkg::*;

    sqrt_t       cell_reg;
    sqrt_t       cell_next;
    logic [19:0] r2;
    logic [19:0] trial;
    logic [19:0] diff;
    logic        ge;

    always_comb
    begin
        r2    = {cin.rem, cin.n[33:32]};
        trial = {1'b0, cin.root, 2'b01};
        diff  = r2 - trial;
        ge    = (r2 >= trial);
        cell_next.n    = {cin.n[31:0], 2'b00};
        cell_next.rem  = ge ? diff[17:0] : r2[17:0];
        cell_next.root = {cin.root[15:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cout = cell_reg;
endmodule

// ===== hw/rtl/swk_div_cell.sv =====
// ============================================================================
// swk_div_cell: one quotient bit of the speed normalizing divide
// Shift in the next dividend bit, subtract the divisor where it fits.
// ============================================================================
module swk_div_cell (
    input  logic          clk,
    input  logic          en,
    input  swk_pkg::div_t cin,
    output swk_pkg::div_t cout
);
    import swk_pkg::*;

    div_t        cell_reg;
    div_t        cell_next;
    logic [17:0] r2;
    logic [17:0] diff;
    logic        ge;

    always_comb
    begin
        r2   = {cin.rem, cin.dsh[15]};
        diff = r2 - {1'b0, cin.m};
        ge   = (r2 >= {1'b0, cin.m});
        cell_next     = cin;
        cell_next.rem = ge ? diff[16:0] : r2[16:0];
        cell_next.quo = {cin.quo[14:0], ge};
        cell_next.dsh = {cin.dsh[14:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cout = cell_reg;
endmodule

// ===== hw/rtl/swk_cordic_cell.sv =====
// ============================================================================
// swk_cordic_cell: one vectoring micro-rotation
// Rotate toward the x axis by atan(2^-idx) and track the angle.
// ============================================================================
module swk_cordic_cell (
    input  logic                      clk,
    input  logic                      en,
    input  logic [swk_pkg::STG_W-1:0] idx,
    input  swk_pkg::cordic_t          cin,
    output swk_pkg::cordic_t          cout
);
    import swk_pkg::*;

    cordic_t cell_reg;
    cordic_t cell_next;
    cvec_t   dx;
    cvec_t   dy;

    always_comb
    begin
        dx = cin.y >>> idx;
        dy = cin.x >>> idx;
        cell_next.zero = cin.zero;
        if (cin.y > 0)
        begin
            cell_next.x = cin.x + dx;
            cell_next.y = cin.y - dy;
            cell_next.z = cin.z + atan_entry(idx);
        end
        else
        begin
            cell_next.x = cin.x - dx;
            cell_next.y = cin.y + dy;
            cell_next.z = cin.z - atan_entry(idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cout = cell_reg;
endmodule

// ===== hw/rtl/swerve_wheel_kinematics_unit.sv =====
// ============================================================================
// swerve_wheel_kinematics_unit: four-wheel swerve inverse kinematics
// One drive command in, four wheel speeds and steering angles out.
// ============================================================================
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------
//  cmd     | in  | valid/ready            | drive_x, drive_y, rotate (Q1.15)
//  wheel   | out | valid/ready            | wheel1..4 speed, wheel1..4 angle
//  apb     | in  | psel/penable, pready=1 | length_ratio @0, width_ratio @4
//
//  Throughput is one item per cycle unless the chain holds (see below); the
//  speed path runs through the 17-cell square root chain and the 16-cell divide chain.
//  Every stage advances together; the chain holds only while a result sits
//  in the output register and the sink is not ready.
//  Reset clears the valid line and restores both ratios to 46341.
//
module swerve_wheel_kinematics_unit (
    input  logic        clk,
    input  logic        rst_n,
    swk_cmd_if.sink     cmd,
    swk_wheel_if.source wheel,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import swk_pkg::*;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [15:0] length_ratio_reg;
    logic [15:0] width_ratio_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_ratio_reg <= RATIO_RST;
            width_ratio_reg  <= RATIO_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_LENGTH: length_ratio_reg <= pwdata[15:0];
                REG_WIDTH:  width_ratio_reg  <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_LENGTH: prdata = {16'd0, length_ratio_reg};
            REG_WIDTH:  prdata = {16'd0, width_ratio_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control: one valid bit per stage, all stages advance together
    // ------------------------------------------------------------------
    logic [LAT:1] vld_reg;
    logic         adv;

    assign adv       = ~vld_reg[LAT] | wheel.ready;
    assign cmd.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-1:1], cmd.valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: rotation products
    // Stage 2: wheel pair terms A..D
    // ------------------------------------------------------------------
    logic signed [15:0] x1_reg, y1_reg;
    logic signed [32:0] pl1_reg, pw1_reg;
    logic signed [32:0] pl_next, pw_next;
    logic signed [32:0] tl_sum, tw_sum;
    logic signed [16:0] tl, tw;
    logic signed [17:0] a2_reg, b2_reg, c2_reg, d2_reg;
    logic signed [17:0] x1_ext, y1_ext, tl_ext, tw_ext;

    assign pl_next = cmd.rotate * $signed({1'b0, length_ratio_reg});
    assign pw_next = cmd.rotate * $signed({1'b0, width_ratio_reg});

    always_comb
    begin
        // round to nearest, ties toward plus infinity
        tl_sum = pl1_reg + 33'sd32768;
        tw_sum = pw1_reg + 33'sd32768;
        tl     = tl_sum[32:16];
        tw     = tw_sum[32:16];
        x1_ext = {{2{x1_reg[15]}}, x1_reg};
        y1_ext = {{2{y1_reg[15]}}, y1_reg};
        tl_ext = {tl[16], tl};
        tw_ext = {tw[16], tw};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg  <= cmd.drive_x;
            y1_reg  <= cmd.drive_y;
            pl1_reg <= pl_next;
            pw1_reg <= pw_next;
            a2_reg  <= x1_ext - tl_ext;
            b2_reg  <= x1_ext + tl_ext;
            c2_reg  <= y1_ext - tw_ext;
            d2_reg  <= y1_ext + tw_ext;
        end
    end

    // Wheel pairs (first, second): 1 (B,C), 2 (B,D), 3 (A,D), 4 (A,C)
    logic signed [17:0] pf [4];
    logic signed [17:0] ps [4];

    always_comb
    begin
        pf[0] = b2_reg; ps[0] = c2_reg;
        pf[1] = b2_reg; ps[1] = d2_reg;
        pf[2] = a2_reg; ps[2] = d2_reg;
        pf[3] = a2_reg; ps[3] = c2_reg;
    end

    // ------------------------------------------------------------------
    // Speed path: squares (stage 3), sums (stage 4), square root chain
    // ------------------------------------------------------------------
    logic [31:0]        sq3_reg [4];
    logic signed [35:0] sq_full [4];
    sqrt_t              sq_init_reg [4];
    sqrt_t              sq_w [4][SQRT_CELLS];

    always_comb
    begin
        sq_full[0] = a2_reg * a2_reg;
        sq_full[1] = b2_reg * b2_reg;
        sq_full[2] = c2_reg * c2_reg;
        sq_full[3] = d2_reg * d2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                sq3_reg[k] <= sq_full[k][31:0];
            end
            // index of sq3_reg: 0 A, 1 B, 2 C, 3 D
            sq_init_reg[0] <= '{n: {1'b0, {1'b0, sq3_reg[1]} + {1'b0, sq3_reg[2]}},
                                rem: '0, root: '0};
            sq_init_reg[1] <= '{n: {1'b0, {1'b0, sq3_reg[1]} + {1'b0, sq3_reg[3]}},
                                rem: '0, root: '0};
            sq_init_reg[2] <= '{n: {1'b0, {1'b0, sq3_reg[0]} + {1'b0, sq3_reg[3]}},
                                rem: '0, root: '0};
            sq_init_reg[3] <= '{n: {1'b0, {1'b0, sq3_reg[0]} + {1'b0, sq3_reg[2]}},
                                rem: '0, root: '0};
        end
    end

    for (genvar w = 0; w < 4; w++)
    begin : g_sqrt
        for (genvar j = 0; j < SQRT_CELLS; j++)
        begin : g_cell
            if (j == 0)
            begin : g_first
                swk_sqrt_cell u_cell (.clk(clk), .en(adv), .cin(sq_init_reg[w]),
                                      .cout(sq_w[w][j]));
            end
            else
            begin : g_next
                swk_sqrt_cell u_cell (.clk(clk), .en(adv), .cin(sq_w[w][j-1]),
                                      .cout(sq_w[w][j]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Normalization: find the largest speed, then divide chain
    // Quotient is floor(s * 32768 / M); the first 16 dividend bits leave
    // s >> 1 as remainder, so the chain starts there.
    // ------------------------------------------------------------------
    logic [16:0] spd [4];
    logic [16:0] m01, m23, mx;
    div_t        dv_init_reg [4];
    div_t        dv_w [4][DIV_CELLS];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            spd[k] = sq_w[k][SQRT_CELLS-1].root;
        end
        m01 = (spd[1] > spd[0]) ? spd[1] : spd[0];
        m23 = (spd[3] > spd[2]) ? spd[3] : spd[2];
        mx  = (m23 > m01) ? m23 : m01;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                dv_init_reg[k] <= '{m: mx, s: spd[k], big: (mx > ONE_Q15),
                                    rem: {1'b0, spd[k][16:1]}, quo: '0,
                                    dsh: {spd[k][0], 15'd0}};
            end
        end
    end

    for (genvar w = 0; w < 4; w++)
    begin : g_div
        for (genvar j = 0; j < DIV_CELLS; j++)
        begin : g_cell
            if (j == 0)
            begin : g_first
                swk_div_cell u_cell (.clk(clk), .en(adv), .cin(dv_init_reg[w]),
                                     .cout(dv_w[w][j]));
            end
            else
            begin : g_next
                swk_div_cell u_cell (.clk(clk), .en(adv), .cin(dv_w[w][j-1]),
                                     .cout(dv_w[w][j]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Angle path: pre-rotation (stage 3), CORDIC chain, delay to align
    // ------------------------------------------------------------------
    cordic_t     cd_init_reg [4];
    cordic_t     cd_w [4][CORDIC_STAGES];
    logic [15:0] ang_dly_reg [ANG_DLY][4];
    logic [15:0] ang_fin [4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                // vector (x = second, y = first) scaled by 2^14;
                // flip by a half turn when x is negative
                cd_init_reg[k].zero <= (pf[k] == 18'sd0) && (ps[k] == 18'sd0);
                if (ps[k] < 0)
                begin
                    cd_init_reg[k].x <= -(cvec_t'(ps[k]) <<< 14);
                    cd_init_reg[k].y <= -(cvec_t'(pf[k]) <<< 14);
                    cd_init_reg[k].z <= 32'h80000000;
                end
                else
                begin
                    cd_init_reg[k].x <= cvec_t'(ps[k]) <<< 14;
                    cd_init_reg[k].y <= cvec_t'(pf[k]) <<< 14;
                    cd_init_reg[k].z <= 32'h00000000;
                end
            end
        end
    end

    for (genvar w = 0; w < 4; w++)
    begin : g_cordic
        for (genvar j = 0; j < CORDIC_STAGES; j++)
        begin : g_cell
            if (j == 0)
            begin : g_first
                swk_cordic_cell u_cell (.clk(clk), .en(adv), .idx(STG_W'(j)),
                                        .cin(cd_init_reg[w]), .cout(cd_w[w][j]));
            end
            else
            begin : g_next
                swk_cordic_cell u_cell (.clk(clk), .en(adv), .idx(STG_W'(j)),
                                        .cin(cd_w[w][j-1]), .cout(cd_w[w][j]));
            end
        end
    end

    // round to 16 bits, then half turn minus the angle
    logic [32:0] z_rnd [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            z_rnd[k]   = {1'b0, cd_w[k][CORDIC_STAGES-1].z} + 33'd32768;
            ang_fin[k] = cd_w[k][CORDIC_STAGES-1].zero ? HALF_TURN
                                                       : HALF_TURN - z_rnd[k][31:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang_dly_reg[0] <= ang_fin;
            for (int d = 1; d < ANG_DLY; d++)
            begin
                ang_dly_reg[d] <= ang_dly_reg[d-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [15:0] spd_out_reg [4];
    logic [15:0] ang_out_reg [4];
    div_t        dv_last [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            dv_last[k] = dv_w[k][DIV_CELLS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                spd_out_reg[k] <= dv_last[k].big ? dv_last[k].quo : dv_last[k].s[15:0];
                ang_out_reg[k] <= ang_dly_reg[ANG_DLY-1][k];
            end
        end
    end

    assign wheel.valid        = vld_reg[LAT];
    assign wheel.wheel1_speed = spd_out_reg[0];
    assign wheel.wheel2_speed = spd_out_reg[1];
    assign wheel.wheel3_speed = spd_out_reg[2];
    assign wheel.wheel4_speed = spd_out_reg[3];
    assign wheel.wheel1_angle = ang_out_reg[0];
    assign wheel.wheel2_angle = ang_out_reg[1];
    assign wheel.wheel3_angle = ang_out_reg[2];
    assign wheel.wheel4_angle = ang_out_reg[3];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (wheel.valid && !wheel.ready))
        else $error("command stalled without a blocked result");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> vld_reg[1])
        else $error("accepted command missing from first stage");

    a_speed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wheel.valid |-> (wheel.wheel1_speed <= 16'd32768 &&
                         wheel.wheel2_speed <= 16'd32768 &&
                         wheel.wheel3_speed <= 16'd32768 &&
                         wheel.wheel4_speed <= 16'd32768))
        else $error("wheel speed above full scale");

endmodule

// ===== sim/tb.sv =====
// ============================================================================
// tb: swerve wheel kinematics unit testbench
// Drives drive commands through the cmd channel and programs both ratios over
// APB. A predictor in the bench works out wheel speeds and steering angles.
// Every wheel item is checked against the oldest prediction. Directed rows
// come first, then random phases under several ratio settings.
// ============================================================================
module tb;
    import swk_pkg::*;

    typedef struct packed {
        logic [15:0] s1, s2, s3, s4;
        logic [15:0] a1, a2, a3, a4;
    } wheel_set_t;

    // one row of the directed table; chk marks rows with a typed-in answer
    typedef struct {
        logic signed [15:0] x, y, r;
        bit                 chk;
        wheel_set_t         res;
    } cmd_row_t;

    localparam int    WDOG_LIMIT = 5000;
    localparam int    HOLD_LEN   = 300;
    localparam logic [2:0] ADDR_LENGTH = 3'd0;
    localparam logic [2:0] ADDR_WIDTH  = 3'd4;

    // arctangent of 2^-i, 2^32 units per turn
    localparam bit [31:0] ARCTAN_TURNS [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    swk_cmd_if   cmd_ch ();
    swk_wheel_if wheel_ch ();

    swerve_wheel_kinematics_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .wheel   (wheel_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // bench copy of the ratio registers
    logic [15:0] length_ratio_q;
    logic [15:0] width_ratio_q;

    wheel_set_t  pending_wheels[$];
    int          mismatch_count;
    int          cmds_accepted;
    int          idle_cycles;
    int          stall_pct;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // 180 degrees minus atan2(first, second) as a binary angle
    function automatic logic [15:0] steer_code(input longint first, input longint second);
        longint   vx;
        longint   vy;
        longint   dx;
        longint   dy;
        bit [31:0] z;
        longint   rounded;
        if (first == 0 && second == 0)
            return HALF_TURN;
        vx = second * 16384;
        vy = first * 16384;
        z  = 32'd0;
        // fold the left half plane over by a half turn
        if (vx < 0)
        begin
            vx = -vx;
            vy = -vy;
            z  = 32'h80000000;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0)
            begin
                vx = vx + dx;
                vy = vy - dy;
                z  = z + ARCTAN_TURNS[i];
            end
            else
            begin
                vx = vx - dx;
                vy = vy + dy;
                z  = z - ARCTAN_TURNS[i];
            end
        end
        rounded = (longint'(z) + 32768) >>> 16;
        return 16'(32768 - rounded);
    endfunction

    function automatic wheel_set_t wheels_from_cmd(input logic signed [15:0] x,
                                                   input logic signed [15:0] y,
                                                   input logic signed [15:0] r);
        longint          tl, tw, a, b, c, d;
        longint unsigned spd[4];
        longint unsigned peak;
        wheel_set_t      w;
        tl = (longint'(r) * longint'(length_ratio_q) + 32768) >>> 16;
        tw = (longint'(r) * longint'(width_ratio_q) + 32768) >>> 16;
        a  = x - tl;
        b  = x + tl;
        c  = y - tw;
        d  = y + tw;
        spd[0] = int_sqrt(b * b + c * c);
        spd[1] = int_sqrt(b * b + d * d);
        spd[2] = int_sqrt(a * a + d * d);
        spd[3] = int_sqrt(a * a + c * c);
        peak = spd[0];
        for (int k = 1; k < 4; k++)
            if (spd[k] > peak)
                peak = spd[k];
        // scale all four down when the fastest wheel exceeds full speed
        if (peak > 32768)
            for (int k = 0; k < 4; k++)
                spd[k] = (spd[k] * 32768) / peak;
        w.s1 = 16'(spd[0]);
        w.s2 = 16'(spd[1]);
        w.s3 = 16'(spd[2]);
        w.s4 = 16'(spd[3]);
        w.a1 = steer_code(b, c);
        w.a2 = steer_code(b, d);
        w.a3 = steer_code(a, d);
        w.a4 = steer_code(a, c);
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: predict on every accepted command, check every wheel item
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        wheel_set_t want;
        wheel_set_t got;
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                pending_wheels.push_back(wheels_from_cmd(cmd_ch.drive_x, cmd_ch.drive_y,
                                                         cmd_ch.rotate));
                cmds_accepted++;
            end
            if (wheel_ch.valid && wheel_ch.ready)
            begin
                got = '{wheel_ch.wheel1_speed, wheel_ch.wheel2_speed,
                        wheel_ch.wheel3_speed, wheel_ch.wheel4_speed,
                        wheel_ch.wheel1_angle, wheel_ch.wheel2_angle,
                        wheel_ch.wheel3_angle, wheel_ch.wheel4_angle};
                if (pending_wheels.size() == 0)
                begin
                    $error("wheel item with no command outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_wheels.pop_front();
                    if (got.s1 !== want.s1)
                    begin
                        $error("wheel1_speed expected %0d got %0d", want.s1, got.s1);
                        mismatch_count++;
                    end
                    if (got.s2 !== want.s2)
                    begin
                        $error("wheel2_speed expected %0d got %0d", want.s2, got.s2);
                        mismatch_count++;
                    end
                    if (got.s3 !== want.s3)
                    begin
                        $error("wheel3_speed expected %0d got %0d", want.s3, got.s3);
                        mismatch_count++;
                    end
                    if (got.s4 !== want.s4)
                    begin
                        $error("wheel4_speed expected %0d got %0d", want.s4, got.s4);
                        mismatch_count++;
                    end
                    if (got.a1 !== want.a1)
                    begin
                        $error("wheel1_angle expected %0d got %0d", want.a1, got.a1);
                        mismatch_count++;
                    end
                    if (got.a2 !== want.a2)
                    begin
                        $error("wheel2_angle expected %0d got %0d", want.a2, got.a2);
                        mismatch_count++;
                    end
                    if (got.a3 !== want.a3)
                    begin
                        $error("wheel3_angle expected %0d got %0d", want.a3, got.a3);
                        mismatch_count++;
                    end
                    if (got.a4 !== want.a4)
                    begin
                        $error("wheel4_angle expected %0d got %0d", want.a4, got.a4);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog: count cycles in which nothing moves on either channel
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (wheel_ch.valid && wheel_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: stall on its own random pattern; once, hold off for a long
    // stretch so the pipeline fills and backs up into the command channel
    initial
    begin
        int  run;
        bit  held;
        wheel_ch.ready = 1'b0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && cmds_accepted >= 400)
            begin
                held = 1'b1;
                wheel_ch.ready = 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
            end
            run = $urandom_range(1, 12);
            wheel_ch.ready = ($urandom_range(0, 99) >= stall_pct);
            repeat (run - 1) @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] addr, input logic [15:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = {16'h0, value};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (addr == ADDR_LENGTH)
            length_ratio_q = value;
        else
            width_ratio_q = value;
    endtask

    // offer one command and hold it until the block takes it
    task automatic send_cmd(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic signed [15:0] r);
        @(negedge clk);
        cmd_ch.valid   = 1'b1;
        cmd_ch.drive_x = x;
        cmd_ch.drive_y = y;
        cmd_ch.rotate  = r;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // drop valid for a random gap, sometimes none at all
    task automatic sender_gap(input int max_gap);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, max_gap) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (pending_wheels.size() != 0)
            @(posedge clk);
        repeat (LAT + 5) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_field();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'(int'($urandom_range(0, 64)) - 32);
            3:       return 16'sh0;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int n);
        int burst;
        int sent;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < n; k++)
            begin
                send_cmd(rand_field(), rand_field(), rand_field());
                sent++;
            end
            sender_gap(8);
        end
    endtask

    cmd_row_t directed[$];

    initial
    begin
        cmd_row_t row;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = 3'd0;
        pwdata         = 32'd0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.drive_x = 16'sd0;
        cmd_ch.drive_y = 16'sd0;
        cmd_ch.rotate  = 16'sd0;
        length_ratio_q = RATIO_RST;
        width_ratio_q  = RATIO_RST;
        mismatch_count = 0;
        cmds_accepted  = 0;
        idle_cycles    = 0;
        stall_pct      = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero command: all wheels stopped, angles sit at a half turn
        directed.push_back('{16'sd0, 16'sd0, 16'sd0, 1'b1,
                             '{16'd0, 16'd0, 16'd0, 16'd0,
                               HALF_TURN, HALF_TURN, HALF_TURN, HALF_TURN}});
        directed.push_back('{16'sh8000, 16'sd0, 16'sd0, 1'b0, '0});
        directed.push_back('{16'sh7FFF, 16'sd0, 16'sd0, 1'b0, '0});
        directed.push_back('{16'sd0, 16'sh8000, 16'sd0, 1'b0, '0});
        directed.push_back('{16'sd0, 16'sh7FFF, 16'sd0, 1'b0, '0});
        directed.push_back('{16'sd0, 16'sd0, 16'sh8000, 1'b0, '0});
        directed.push_back('{16'sd0, 16'sd0, 16'sh7FFF, 1'b0, '0});
        directed.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0});
        directed.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, '0});
        directed.push_back('{16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0, '0});
        directed.push_back('{16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0, '0});
        directed.push_back('{16'sd1, 16'sd0, 16'sd0, 1'b0, '0});
        directed.push_back('{16'sd0, -16'sd1, 16'sd0, 1'b0, '0});
        directed.push_back('{-16'sd1, 16'sd1, 16'sd1, 1'b0, '0});
        directed.push_back('{16'sd16384, 16'sd16384, 16'sd0, 1'b0, '0});
        directed.push_back('{16'sd23170, -16'sd23170, 16'sd8000, 1'b0, '0});

        // directed rows, receiver always ready; typed answers checked here too
        foreach (directed[i])
        begin
            row = directed[i];
            send_cmd(row.x, row.y, row.r);
            if (row.chk && wheels_from_cmd(row.x, row.y, row.r) !== row.res)
            begin
                $error("directed row %0d: predictor disagrees with typed result", i);
                mismatch_count++;
            end
        end
        drain();

        // random phases, each under its own ratio setting and stall rate
        stall_pct = 30;
        random_phase(600);
        drain();

        apb_write(ADDR_LENGTH, 16'd0);
        apb_write(ADDR_WIDTH, 16'd0);
        stall_pct = 0;
        random_phase(250);
        drain();

        apb_write(ADDR_LENGTH, 16'hFFFF);
        apb_write(ADDR_WIDTH, 16'hFFFF);
        stall_pct = 60;
        random_phase(300);
        drain();

        apb_write(ADDR_LENGTH, 16'hFFFF);
        apb_write(ADDR_WIDTH, 16'd0);
        stall_pct = 20;
        random_phase(250);
        drain();

        apb_write(ADDR_LENGTH, 16'($urandom));
        apb_write(ADDR_WIDTH, 16'($urandom));
        stall_pct = 40;
        random_phase(400);
        drain();

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
